FILE: rtl/stopwatch_countdown_timer_assert.svh
// Assertion macros for the stopwatch/countdown timer checker
`ifndef STOPWATCH_COUNTDOWN_TIMER_ASSERT_SVH
`define STOPWATCH_COUNTDOWN_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swt: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swt: assertion failed");

`endif

FILE: rtl/swt_pkg.sv
// Shared types and constants of the stopwatch/countdown timer
package swt_pkg;

    localparam int TIME_W   = 32;
    localparam int OP_W     = 3;
    localparam int AMT_W    = 23;
    localparam int UNIT_W   = 2;
    localparam int HOURS_W  = 11;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd359999000;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

    localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_MIN  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;

    // milliseconds per add unit
    localparam int SCALE_W = 22;
    localparam logic [SCALE_W-1:0] MS_PER_SEC  = 22'd1000;
    localparam logic [SCALE_W-1:0] MS_PER_MIN  = 22'd60000;
    localparam logic [SCALE_W-1:0] MS_PER_HOUR = 22'd3600000;
    localparam int ADD_W = AMT_W + SCALE_W;

    // reciprocal constants: x/1000 and x/60 by multiply and shift
    localparam int DIV1000_MUL_W = 29;
    localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;
    localparam int DIV1000_SHIFT = 38;
    localparam int DIV60_MUL_W = 24;
    localparam logic [DIV60_MUL_W-1:0] DIV60_MUL = 24'd8947849;
    localparam int DIV60_SHIFT = 29;
    localparam int SECS_W = 23;
    localparam int MTOT_W = 17;
    localparam int PER_SIXTY = 60;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_TOGGLE,
        CMD_ADD,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [ADD_W-1:0] add_ms;
    } cmd_t;

    typedef struct packed {
        logic              countdown;
        logic              running;
        logic [TIME_W-1:0] stored;
        logic [TIME_W-1:0] elapsed;
    } snap_t;

endpackage

FILE: rtl/swt_ifs.sv
// Channel interfaces of the stopwatch/countdown timer
interface swt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [swt_pkg::OP_W-1:0]    op;
    logic [swt_pkg::AMT_W-1:0]   add_amount;
    logic [swt_pkg::UNIT_W-1:0]  add_unit;

    modport source (output valid, op, add_amount, add_unit, input ready);
    modport sink   (input valid, op, add_amount, add_unit, output ready);
endinterface

interface swt_rpt_if;
    logic                        valid;
    logic                        ready;
    logic [swt_pkg::HOURS_W-1:0] hours;
    logic [swt_pkg::MIN_W-1:0]   minutes;
    logic [swt_pkg::SEC_W-1:0]   seconds;
    logic                        running;
    logic                        countdown_mode;
    logic                        finished;

    modport source (output valid, hours, minutes, seconds, running, countdown_mode,
                    finished, input ready);
    modport sink   (input valid, hours, minutes, seconds, running, countdown_mode,
                    finished, output ready);
endinterface

interface swt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [swt_pkg::TIME_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/swt_front.sv
// Front end: takes commands, decodes them and scales add amounts to ms
module swt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [swt_pkg::OP_W-1:0]   op,
    input  logic [swt_pkg::AMT_W-1:0]  add_amount,
    input  logic [swt_pkg::UNIT_W-1:0] add_unit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output swt_pkg::cmd_t              out_cmd
);

    logic                         valid_reg;
    swt_pkg::cmd_t                cmd_reg;
    swt_pkg::cmd_t                cmd_next;
    logic [swt_pkg::SCALE_W-1:0]  scale;
    logic                         take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

    always_comb
    begin
        case (add_unit)
            swt_pkg::UNIT_SEC:  scale = swt_pkg::MS_PER_SEC;
            swt_pkg::UNIT_MIN:  scale = swt_pkg::MS_PER_MIN;
            swt_pkg::UNIT_HOUR: scale = swt_pkg::MS_PER_HOUR;
            default:            scale = '0;
        endcase

        cmd_next.add_ms = swt_pkg::ADD_W'(add_amount) * swt_pkg::ADD_W'(scale);
        case (op)
            swt_pkg::OP_TICK:   cmd_next.kind = swt_pkg::CMD_TICK;
            swt_pkg::OP_START:  cmd_next.kind = swt_pkg::CMD_START;
            swt_pkg::OP_STOP:   cmd_next.kind = swt_pkg::CMD_STOP;
            swt_pkg::OP_TOGGLE: cmd_next.kind = swt_pkg::CMD_TOGGLE;
            swt_pkg::OP_ADD:
            begin
                if (add_unit inside {swt_pkg::UNIT_SEC, swt_pkg::UNIT_MIN, swt_pkg::UNIT_HOUR})
                    cmd_next.kind = swt_pkg::CMD_ADD;
                else
                    cmd_next.kind = swt_pkg::CMD_NOP;
            end
            swt_pkg::OP_RESET:  cmd_next.kind = swt_pkg::CMD_CLEAR;
            default:            cmd_next.kind = swt_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_next;
    end

endmodule

FILE: rtl/swt_fifo.sv
// Command queue between front end and execution stage
module swt_fifo #(
    parameter int DEPTH = swt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  swt_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output swt_pkg::cmd_t out_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    swt_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

FILE: rtl/swt_exec.sv
// Execution stage: timer state, limit register and per-command update
module swt_exec (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  swt_pkg::cmd_t              cmd,
    input  logic                       adv,
    input  logic                       cfg_valid,
    input  logic [swt_pkg::TIME_W-1:0] cfg_data,
    output logic                       snap_valid,
    output swt_pkg::snap_t             snap
);

    localparam int TW    = swt_pkg::TIME_W;
    localparam int SUM_W = swt_pkg::ADD_W + 1;

    logic [TW-1:0] now_reg, now_next;
    logic [TW-1:0] elapsed_reg, elapsed_next;   // always now - start stamp
    logic [TW-1:0] stored_reg, stored_next;
    logic [TW-1:0] limit_reg;
    logic [TW-1:0] stored_base;
    logic          countdown_reg, countdown_next;
    logic          running_reg, running_next;
    logic          is_tick, do_start, do_stop, clear, add_ok, pop;
    logic [SUM_W-1:0] add_sum;

    assign pop        = cmd_valid && adv;
    assign snap_valid = pop;
    assign add_sum    = SUM_W'(stored_reg) + SUM_W'(cmd.add_ms);
    assign add_ok     = (cmd.kind == swt_pkg::CMD_ADD) && (add_sum <= SUM_W'(limit_reg));

    always_comb
    begin
        is_tick  = 1'b0;
        do_start = 1'b0;
        do_stop  = 1'b0;
        clear    = 1'b0;
        case (cmd.kind)
            swt_pkg::CMD_TICK:   is_tick = 1'b1;
            swt_pkg::CMD_START:  do_start = 1'b1;
            swt_pkg::CMD_STOP:   do_stop = 1'b1;
            swt_pkg::CMD_TOGGLE:
            begin
                do_start = !running_reg;
                do_stop  = running_reg;
            end
            swt_pkg::CMD_CLEAR:
            begin
                do_stop = 1'b1;
                clear   = 1'b1;
            end
            default: ;
        endcase

        now_next = is_tick ? now_reg + 1'b1 : now_reg;

        if (is_tick)
            elapsed_next = elapsed_reg + 1'b1;
        else if (do_start)
            elapsed_next = countdown_reg ? '0 : stored_reg;
        else if (do_stop)
            elapsed_next = now_reg;   // stamp cleared to zero
        else
            elapsed_next = elapsed_reg;

        if (do_start)
            running_next = 1'b1;
        else if (do_stop)
            running_next = 1'b0;
        else
            running_next = running_reg;

        countdown_next = countdown_reg;
        stored_base    = stored_reg;
        if (clear)
        begin
            countdown_next = 1'b0;
            stored_base    = '0;
        end
        else if (add_ok)
        begin
            countdown_next = 1'b1;
            stored_base    = add_sum[TW-1:0];
        end

        // running stopwatch shows elapsed time, saturated at the limit
        if (!countdown_next && running_next)
            stored_next = (elapsed_next >= limit_reg) ? limit_reg : elapsed_next;
        else
            stored_next = stored_base;

        snap.countdown = countdown_next;
        snap.running   = running_next;
        snap.stored    = stored_next;
        snap.elapsed   = elapsed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            elapsed_reg   <= '0;
            stored_reg    <= '0;
            countdown_reg <= 1'b0;
            running_reg   <= 1'b0;
            limit_reg     <= swt_pkg::LIMIT_RESET;
        end
        else
        begin
            if (pop)
            begin
                now_reg       <= now_next;
                elapsed_reg   <= elapsed_next;
                stored_reg    <= stored_next;
                countdown_reg <= countdown_next;
                running_reg   <= running_next;
            end
            if (cfg_valid)
                limit_reg <= cfg_data;
        end
    end

endmodule

FILE: rtl/swt_fmt.sv
// Report pipeline: shown time, then ms to hours/minutes/seconds
module swt_fmt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        snap_valid,
    input  swt_pkg::snap_t              snap,
    output logic                        adv,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [swt_pkg::HOURS_W-1:0] hours,
    output logic [swt_pkg::MIN_W-1:0]   minutes,
    output logic [swt_pkg::SEC_W-1:0]   seconds,
    output logic                        running,
    output logic                        countdown_mode,
    output logic                        finished
);

    localparam int TW     = swt_pkg::TIME_W;
    localparam int SW     = swt_pkg::SECS_W;
    localparam int MW     = swt_pkg::MTOT_W;
    localparam int HW     = swt_pkg::HOURS_W;
    localparam int P1_W   = TW + swt_pkg::DIV1000_MUL_W;
    localparam int P2_W   = SW + swt_pkg::DIV60_MUL_W;
    localparam int P3_W   = MW + swt_pkg::DIV60_MUL_W;

    typedef struct packed {
        logic running;
        logic countdown;
        logic finished;
    } flags_t;

    logic             va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vo_reg;
    swt_pkg::snap_t   snap_reg;
    logic [TW-1:0]    shown_reg;
    logic [SW-1:0]    secs_c_reg, secs_d_reg;
    logic [MW-1:0]    mtot_d_reg, mtot_e_reg;
    logic [HW-1:0]    hours_e_reg, hours_reg;
    logic [swt_pkg::SEC_W-1:0] secs_e_reg, secs_reg;
    logic [swt_pkg::MIN_W-1:0] mins_reg;
    flags_t           flg_b_reg, flg_c_reg, flg_d_reg, flg_e_reg, flg_reg;

    logic             fin_b;
    logic [TW-1:0]    shown_b;
    logic [P1_W-1:0]  prod1;
    logic [P2_W-1:0]  prod2;
    logic [P3_W-1:0]  prod3;
    logic [SW-1:0]    sec_rem;
    logic [MW-1:0]    min_rem;

    assign adv = !vo_reg || out_ready;

    always_comb
    begin
        fin_b = snap_reg.countdown && snap_reg.running &&
                (snap_reg.elapsed >= snap_reg.stored);
        if (snap_reg.countdown && snap_reg.running && !fin_b)
            shown_b = snap_reg.stored - snap_reg.elapsed;
        else
            shown_b = snap_reg.stored;

        prod1   = P1_W'(shown_reg) * P1_W'(swt_pkg::DIV1000_MUL);
        prod2   = P2_W'(secs_c_reg) * P2_W'(swt_pkg::DIV60_MUL);
        prod3   = P3_W'(mtot_d_reg) * P3_W'(swt_pkg::DIV60_MUL);
        sec_rem = secs_d_reg - SW'(mtot_d_reg) * SW'(swt_pkg::PER_SIXTY);
        min_rem = mtot_e_reg - MW'(hours_e_reg) * MW'(swt_pkg::PER_SIXTY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= snap_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vo_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            snap_reg    <= snap;

            shown_reg   <= shown_b;
            flg_b_reg   <= '{running: snap_reg.running, countdown: snap_reg.countdown,
                             finished: fin_b};

            secs_c_reg  <= prod1[swt_pkg::DIV1000_SHIFT +: SW];
            flg_c_reg   <= flg_b_reg;

            mtot_d_reg  <= prod2[swt_pkg::DIV60_SHIFT +: MW];
            secs_d_reg  <= secs_c_reg;
            flg_d_reg   <= flg_c_reg;

            hours_e_reg <= prod3[swt_pkg::DIV60_SHIFT +: HW];
            secs_e_reg  <= sec_rem[swt_pkg::SEC_W-1:0];
            mtot_e_reg  <= mtot_d_reg;
            flg_e_reg   <= flg_d_reg;

            hours_reg   <= hours_e_reg;
            mins_reg    <= min_rem[swt_pkg::MIN_W-1:0];
            secs_reg    <= secs_e_reg;
            flg_reg     <= flg_e_reg;
        end
    end

    assign out_valid      = vo_reg;
    assign hours          = hours_reg;
    assign minutes        = mins_reg;
    assign seconds        = secs_reg;
    assign running        = flg_reg.running;
    assign countdown_mode = flg_reg.countdown;
    assign finished       = flg_reg.finished;

endmodule

FILE: rtl/stopwatch_countdown_timer.sv
// Top level of the millisecond stopwatch/countdown timer
// Takes one command per clock on cmd while rpt is ready, and returns one report per command
// on rpt, in order. A command is decoded in the front stage, waits in a short queue, updates
// the timer state in the execution stage, and the report then passes six pipeline stages
// that turn milliseconds into hours, minutes and seconds by reciprocal multiplies. A stalled
// rpt holds the report pipeline; cmd keeps taking commands until the front register and the
// queue are full. The time limit register is to be written through cfg only while the timer
// is idle; the block itself does not enforce this.
module stopwatch_countdown_timer #(
    parameter int QUEUE_DEPTH = swt_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    swt_cmd_if.sink   cmd,
    swt_rpt_if.source rpt,
    swt_cfg_if.sink   cfg
);

    logic           f_valid, f_ready;
    swt_pkg::cmd_t  f_cmd;
    logic           q_valid;
    swt_pkg::cmd_t  q_cmd;
    logic           adv;
    logic           snap_valid;
    swt_pkg::snap_t snap;

    assign cfg.ready = 1'b1;

    swt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .op         (cmd.op),
        .add_amount (cmd.add_amount),
        .add_unit   (cmd.add_unit),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_cmd    (f_cmd)
    );

    swt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (adv),
        .out_cmd   (q_cmd)
    );

    swt_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd),
        .adv        (adv),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    swt_fmt u_fmt (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_valid     (snap_valid),
        .snap           (snap),
        .adv            (adv),
        .out_valid      (rpt.valid),
        .out_ready      (rpt.ready),
        .hours          (rpt.hours),
        .minutes        (rpt.minutes),
        .seconds        (rpt.seconds),
        .running        (rpt.running),
        .countdown_mode (rpt.countdown_mode),
        .finished       (rpt.finished)
    );

endmodule

FILE: rtl/swt_checker.sv
// Port-level checker for the stopwatch/countdown timer, bound to the top level
`include "stopwatch_countdown_timer_assert.svh"

module swt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rpt_valid,
    input logic                        rpt_ready,
    input logic [swt_pkg::HOURS_W-1:0] rpt_hours,
    input logic [swt_pkg::MIN_W-1:0]   rpt_minutes,
    input logic [swt_pkg::SEC_W-1:0]   rpt_seconds,
    input logic                        rpt_running,
    input logic                        rpt_countdown_mode,
    input logic                        rpt_finished
);

    logic [7:0] pending_reg;
    logic       cmd_xfer, rpt_xfer;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign rpt_xfer = rpt_valid && rpt_ready;

    // commands taken whose report has not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (cmd_xfer && !rpt_xfer)
            pending_reg <= pending_reg + 1'b1;
        else if (rpt_xfer && !cmd_xfer)
            pending_reg <= pending_reg - 1'b1;
    end

    `SWT_ASSERT_IMPL(a_no_extra_report, rpt_valid, pending_reg != 8'd0)
    `SWT_ASSERT_IMPL(a_time_fields, rpt_valid, rpt_minutes < 6'd60 && rpt_seconds < 6'd60)
    `SWT_ASSERT_IMPL(a_finished_mode, rpt_valid && rpt_finished, rpt_running && rpt_countdown_mode)
    `SWT_ASSERT_NEXT(a_report_hold, rpt_valid && !rpt_ready, rpt_valid && $stable({rpt_hours, rpt_minutes, rpt_seconds, rpt_running, rpt_countdown_mode, rpt_finished}))

endmodule

bind stopwatch_countdown_timer swt_checker u_swt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rpt_valid          (rpt.valid),
    .rpt_ready          (rpt.ready),
    .rpt_hours          (rpt.hours),
    .rpt_minutes        (rpt.minutes),
    .rpt_seconds        (rpt.seconds),
    .rpt_running        (rpt.running),
    .rpt_countdown_mode (rpt.countdown_mode),
    .rpt_finished       (rpt.finished)
);
